// File: sv/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned CountW    = 11;
  localparam int unsigned SizeW     = 16;
  localparam int unsigned OffsetW   = 26;
  localparam int unsigned LinkBytes = 8;

  localparam logic [1:0] OpAlloc  = 2'd0;
  localparam logic [1:0] OpFree   = 2'd1;
  localparam logic [1:0] OpResize = 2'd2;

  localparam logic RegBlockSize  = 1'b0;
  localparam logic RegBlockCount = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [SizeW-1:0] request_size;
    logic [IdxW-1:0]  block_index;
    logic             pointer_present;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic               granted;
    logic [IdxW-1:0]    result_index;
    logic [OffsetW-1:0] byte_offset;
    logic [CountW-1:0]  free_count;
  } rsp_t;

endpackage

`default_nettype wire

// File: sv/fbpa_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module fbpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator with a LIFO free list in RAM.
// The accepted request is held while busy_q is high; done_q then strobes its result on done_o.
// The stack RAM read at the accepting edge is followed by the update and write-back;
//   busy is high while the update is decided, and no new request is taken then.
// Reset (rst_ni low, asynchronous): block_size 64, block_count 1024, all blocks free.
//   No clearing pass: a watermark marks stack slots never written, which read as their index.
// The result receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module fixed_block_pool_allocator_top (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire fbpa_pkg::req_t  req_i,
  output logic                 done_o,
  output fbpa_pkg::rsp_t       rsp_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready
);

  import fbpa_pkg::*;

  // Configuration registers, raw as written.
  logic [SizeW-1:0]  block_size_q;
  logic [CountW-1:0] block_count_q;

  // Stack pointer (free count) and the low watermark: slots below it were never
  // written since the last rebuild and still hold their own index.
  logic [CountW-1:0] free_total_q, free_total_d;
  logic [CountW-1:0] low_q, low_d;

  // Request held while the stack top is read.
  logic busy_q;
  req_t req_q;

  logic done_q;
  rsp_t rsp_q, rsp_d;

  logic accept;
  logic cfg_write;

  logic [SizeW-1:0]  eff_size;
  logic [CountW-1:0] eff_count;
  logic [CountW-1:0] top_pos;
  logic [IdxW-1:0]   rd_data;
  logic [IdxW-1:0]   top_val;
  logic              push;
  logic [IdxW-1:0]   res_idx;
  logic              granted;

  assign accept    = start && !busy_q;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == RegBlockCount) ? {21'd0, block_count_q}
                                                 : {16'd0, block_size_q};

  // Floor the block size at one link word, clamp the count to the store depth.
  assign eff_size  = (block_size_q < SizeW'(LinkBytes)) ? SizeW'(LinkBytes) : block_size_q;
  assign eff_count = (block_count_q > CountW'(MaxBlocks)) ? CountW'(MaxBlocks)
                                                          : block_count_q;

  // Stack top slot; read at the accepting edge, used in the next cycle.
  assign top_pos = free_total_q - CountW'(1);

  fbpa_ram #(
    .Width (IdxW),
    .Depth (MaxBlocks)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (free_total_q[IdxW-1:0]),
    .wdata_i (req_q.block_index),
    .re_i    (accept),
    .raddr_i (top_pos[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  // Slots under the watermark read as their own index.
  assign top_val = (top_pos < low_q) ? top_pos[IdxW-1:0] : rd_data;

  // Decide the request and compute the new stack state.
  always_comb begin
    free_total_d = free_total_q;
    low_d        = low_q;
    push         = 1'b0;
    granted      = 1'b0;
    res_idx      = '0;
    rsp_d        = '0;
    rsp_d.status = ST_OK;
    if (busy_q) begin
      unique case (req_q.opcode)
        OpAlloc: begin
          if (req_q.request_size > eff_size) begin
            rsp_d.status = ST_TOO_LARGE;
          end else if (free_total_q == '0) begin
            rsp_d.status = ST_EMPTY;
          end else begin
            free_total_d = top_pos;
            low_d        = (top_pos < low_q) ? top_pos : low_q;
            res_idx      = top_val;
            granted      = 1'b1;
          end
        end
        OpFree: begin
          if (!req_q.pointer_present) begin
            rsp_d.status = ST_IGNORED;
          end else if ({1'b0, req_q.block_index} >= eff_count) begin
            rsp_d.status = ST_BAD_INDEX;
          end else if (free_total_q >= eff_count) begin
            rsp_d.status = ST_IGNORED;
          end else begin
            push         = 1'b1;
            free_total_d = free_total_q + CountW'(1);
          end
        end
        OpResize: begin
          if (req_q.request_size > eff_size) begin
            rsp_d.status = ST_TOO_LARGE;
          end else if (!req_q.pointer_present) begin
            rsp_d.status = ST_IGNORED;
          end else if ({1'b0, req_q.block_index} >= eff_count) begin
            rsp_d.status = ST_BAD_INDEX;
          end else begin
            res_idx = req_q.block_index;
            granted = 1'b1;
          end
        end
        default: begin
          rsp_d.status = ST_IGNORED;
        end
      endcase
    end
    rsp_d.granted      = granted;
    rsp_d.result_index = res_idx;
    rsp_d.byte_offset  = OffsetW'(res_idx) * OffsetW'(eff_size);
    rsp_d.free_count   = free_total_d;
  end

  // Control state: track the busy request, advance the stack, strobe the result, take config writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      done_q        <= 1'b0;
      block_size_q  <= SizeW'(64);
      block_count_q <= CountW'(MaxBlocks);
      free_total_q  <= CountW'(MaxBlocks);
      low_q         <= CountW'(MaxBlocks);
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (busy_q) begin
        free_total_q <= free_total_d;
        low_q        <= low_d;
      end
      // User writes configuration only while idle (not checked); a count write rebuilds the store.
      if (cfg_write) begin
        if (paddr[2] == RegBlockCount) begin
          block_count_q <= pwdata[CountW-1:0];
          free_total_q  <= (pwdata[CountW-1:0] > CountW'(MaxBlocks)) ? CountW'(MaxBlocks)
                                                                      : pwdata[CountW-1:0];
          low_q         <= CountW'(MaxBlocks);
        end else begin
          block_size_q <= pwdata[SizeW-1:0];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (busy_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// File: sv/fbpa_checker.sv
// Port-level checker for the fixed block pool allocator, bound to the top level.
`default_nettype none

module fbpa_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire fbpa_pkg::rsp_t rsp_o
);

  import fbpa_pkg::*;

  // Every transfer in is followed by its result strobe on done_o.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result missing two cycles after a request transfer");

  // A result only appears for an earlier request transfer.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  // A refused request reports no block.
  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.granted) |-> (rsp_o.result_index == '0 && rsp_o.byte_offset == '0))
    else $error("block reported without a grant");

  // A grant always comes with an ok status.
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.granted) |-> (rsp_o.status == ST_OK))
    else $error("grant with a failing status");

  // A reported free count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.free_count <= CountW'(MaxBlocks)))
    else $error("free count beyond store depth");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire

// File: verif/fixed_block_pool_allocator_top_test.sv
// Self-checking testbench for the fixed block pool allocator: directed plan, then random phases.
module fixed_block_pool_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  // Opcode three has no name in the package; the block must ignore it.
  localparam logic [1:0] OpUnused = 2'd3;
  // Cycles without any transfer before the run is declared hung. The slowest
  // correct stretch is a sender gap after a register read.
  localparam int StallLimit = 1000;
  localparam int NumPhases = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        done_o;
  rsp_t        rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fixed_block_pool_allocator_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Pool model: shadow registers, LIFO free store and free count.
  // ---------------------------------------------------------------------------
  logic [SizeW-1:0]  shadow_block_size;
  logic [CountW-1:0] shadow_block_count;
  logic [IdxW-1:0]   free_store [MaxBlocks];
  int unsigned       free_total;

  // Results still owed by the block, oldest first.
  rsp_t awaited_rsp [$];
  int   mismatches;
  int   idle_cycles;

  // A block always holds at least one link word.
  function automatic int unsigned eff_block_size();
    return (shadow_block_size < LinkBytes) ? LinkBytes : int'(shadow_block_size);
  endfunction

  // Counts above the pool capacity clamp to the capacity.
  function automatic int unsigned eff_block_count();
    return (shadow_block_count > MaxBlocks) ? MaxBlocks : int'(shadow_block_count);
  endfunction

  // Refill the store: entry k holds k, every block free.
  function automatic void refill_store();
    for (int k = 0; k < MaxBlocks; k++) free_store[k] = IdxW'(k);
    free_total = eff_block_count();
  endfunction

  function automatic logic [2:0] reg_addr(input logic idx);
    return {idx, 2'b00};
  endfunction

  // Mirror a register write into the shadow state.
  function automatic void shadow_write(input logic [2:0] addr, input logic [31:0] value);
    if (addr == reg_addr(RegBlockSize)) begin
      shadow_block_size = value[SizeW-1:0];
    end else if (addr == reg_addr(RegBlockCount)) begin
      shadow_block_count = value[CountW-1:0];
      refill_store();
    end
  endfunction

  function automatic logic [31:0] shadow_read(input logic [2:0] addr);
    if (addr == reg_addr(RegBlockSize)) return 32'(shadow_block_size);
    if (addr == reg_addr(RegBlockCount)) return 32'(shadow_block_count);
    return 32'd0;
  endfunction

  // Predict the result of one request and advance the free store.
  function automatic rsp_t pool_predict(input req_t r);
    rsp_t            o;
    int unsigned     size;
    int unsigned     count;
    longint unsigned offset;
    size  = eff_block_size();
    count = eff_block_count();
    o = '0;
    o.status = ST_OK;
    case (r.opcode)
      OpAlloc: begin
        if (r.request_size > size) begin
          o.status = ST_TOO_LARGE;
        end else if (free_total == 0) begin
          o.status = ST_EMPTY;
        end else begin
          free_total--;
          o.result_index = free_store[free_total];
          o.granted = 1'b1;
        end
      end
      OpFree: begin
        if (!r.pointer_present) begin
          o.status = ST_IGNORED;
        end else if (r.block_index >= count) begin
          o.status = ST_BAD_INDEX;
        end else if (free_total >= count) begin
          o.status = ST_IGNORED;
        end else begin
          // Double frees go through: the index is simply pushed again.
          free_store[free_total] = r.block_index;
          free_total++;
        end
      end
      OpResize: begin
        if (r.request_size > size) begin
          o.status = ST_TOO_LARGE;
        end else if (!r.pointer_present) begin
          o.status = ST_IGNORED;
        end else if (r.block_index >= count) begin
          o.status = ST_BAD_INDEX;
        end else begin
          o.result_index = r.block_index;
          o.granted = 1'b1;
        end
      end
      default: o.status = ST_IGNORED;
    endcase
    if (o.granted) begin
      offset = longint'(o.result_index) * longint'(size);
      o.byte_offset = offset[OffsetW-1:0];
    end
    o.free_count = CountW'(free_total);
    return o;
  endfunction

  function automatic req_t mk_req(input logic [1:0] op, input int unsigned size,
                                  input int unsigned idx, input bit present);
    req_t r;
    r.opcode          = op;
    r.request_size    = SizeW'(size);
    r.block_index     = IdxW'(idx);
    r.pointer_present = present;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input status_e st, input bit granted, input int unsigned idx,
                                  input int unsigned offset, input int unsigned fcount);
    rsp_t o;
    o.status       = st;
    o.granted      = granted;
    o.result_index = IdxW'(idx);
    o.byte_offset  = OffsetW'(offset);
    o.free_count   = CountW'(fcount);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every strobe pops the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic compare_rsp(input rsp_t want, input rsp_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      mismatches++;
    end
    if (got.granted !== want.granted) begin
      $error("granted: expected %0d, actual %0d", want.granted, got.granted);
      mismatches++;
    end
    if (got.result_index !== want.result_index) begin
      $error("result_index: expected %0d, actual %0d", want.result_index, got.result_index);
      mismatches++;
    end
    if (got.byte_offset !== want.byte_offset) begin
      $error("byte_offset: expected %0d, actual %0d", want.byte_offset, got.byte_offset);
      mismatches++;
    end
    if (got.free_count !== want.free_count) begin
      $error("free_count: expected %0d, actual %0d", want.free_count, got.free_count);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_rsp.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatches++;
      end else begin
        compare_rsp(awaited_rsp.pop_front(), rsp_o);
      end
    end
  end

  // Watchdog: any request, result or register transfer resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("fixed_block_pool_allocator_top_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change at the falling edge; handshakes are sampled at the
  // rising edge, where the block's outputs still hold their pre-edge values.
  // ---------------------------------------------------------------------------

  // Present one request, hold it until the block takes it, then predict.
  // Called and returns at a falling edge; start stays high so a back-to-back
  // request never drops it within the step.
  task automatic issue(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    predicted = pool_predict(r);
    awaited_rsp.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Insert the sender's gap before the next request.
  task automatic hold_off(input int unsigned gap);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Write a register once the block is idle, then read it back.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] want;
    start = 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_write(addr, value);
    @(negedge clk_i);
    // Back-to-back read transfer: psel stays high, a new setup phase starts.
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    want = shadow_read(addr);
    if (prdata !== want) begin
      $error("prdata: expected %0h, actual %0h", want, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Random request biased toward sizes that fit and indices inside the pool,
  // with a share of oversize, out-of-range, null and unused-opcode noise.
  function automatic req_t random_req();
    int unsigned pick;
    logic [1:0]  op;
    int unsigned size;
    int unsigned idx;
    int unsigned count;
    count = eff_block_count();
    pick  = $urandom_range(0, 99);
    if (pick < 45) op = OpAlloc;
    else if (pick < 80) op = OpFree;
    else if (pick < 96) op = OpResize;
    else op = OpUnused;
    if ($urandom_range(0, 9) == 0) size = $urandom_range(0, 65535);
    else size = $urandom_range(0, eff_block_size());
    if (count == 0 || $urandom_range(0, 9) == 0) idx = $urandom_range(0, MaxBlocks - 1);
    else idx = $urandom_range(0, count - 1);
    return mk_req(op, size, idx, $urandom_range(0, 15) != 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan: register writes and requests, with hand-derived results
  // where they follow directly from the pool state.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit          is_write;
    logic [2:0]  addr;
    logic [31:0] value;
    req_t        req;
    bit          typed;
    rsp_t        want;
  } plan_row_t;

  plan_row_t plan [$];

  task automatic plan_write(input logic idx, input logic [31:0] value);
    plan_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.addr     = reg_addr(idx);
    row.value    = value;
    plan.push_back(row);
  endtask

  task automatic plan_req(input req_t r, input rsp_t want);
    plan_row_t row;
    row = '{default: '0};
    row.req   = r;
    row.typed = 1'b1;
    row.want  = want;
    plan.push_back(row);
  endtask

  initial begin
    int unsigned phase_size  [NumPhases];
    int unsigned phase_count [NumPhases];
    int unsigned phase_items;
    bit          burst;

    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    mismatches  = 0;
    idle_cycles = 0;

    shadow_block_size  = SizeW'(64);
    shadow_block_count = CountW'(1024);
    refill_store();

    // After reset: 64-byte blocks, 1024 blocks, top of store is block 1023.
    plan_req(mk_req(OpAlloc, 0, 0, 1), mk_rsp(ST_OK, 1, 1023, 65472, 1023));
    plan_req(mk_req(OpAlloc, 65535, 0, 1), mk_rsp(ST_TOO_LARGE, 0, 0, 0, 1023));
    plan_req(mk_req(OpAlloc, 64, 0, 1), mk_rsp(ST_OK, 1, 1022, 65408, 1022));
    plan_req(mk_req(OpAlloc, 65, 0, 1), mk_rsp(ST_TOO_LARGE, 0, 0, 0, 1022));
    // Null free is ignored; then a double free whose two frees both go onto the store.
    plan_req(mk_req(OpFree, 0, 0, 0), mk_rsp(ST_IGNORED, 0, 0, 0, 1022));
    plan_req(mk_req(OpFree, 0, 1023, 1), mk_rsp(ST_OK, 0, 0, 0, 1023));
    plan_req(mk_req(OpFree, 0, 1023, 1), mk_rsp(ST_OK, 0, 0, 0, 1024));
    // Free into a full store is dropped.
    plan_req(mk_req(OpFree, 0, 5, 1), mk_rsp(ST_IGNORED, 0, 0, 0, 1024));
    // Resize: size check wins over the null check.
    plan_req(mk_req(OpResize, 65535, 0, 0), mk_rsp(ST_TOO_LARGE, 0, 0, 0, 1024));
    plan_req(mk_req(OpResize, 10, 0, 0), mk_rsp(ST_IGNORED, 0, 0, 0, 1024));
    plan_req(mk_req(OpResize, 64, 1023, 1), mk_rsp(ST_OK, 1, 1023, 65472, 1024));
    plan_req(mk_req(OpUnused, 65535, 1023, 1), mk_rsp(ST_IGNORED, 0, 0, 0, 1024));
    plan_req(mk_req(OpAlloc, 1, 0, 1), mk_rsp(ST_OK, 1, 1023, 65472, 1023));
    // Zero-block pool: always empty, every index bad, though the size check still wins.
    plan_write(RegBlockCount, 32'd0);
    plan_req(mk_req(OpAlloc, 0, 0, 1), mk_rsp(ST_EMPTY, 0, 0, 0, 0));
    plan_req(mk_req(OpFree, 0, 0, 1), mk_rsp(ST_BAD_INDEX, 0, 0, 0, 0));
    plan_req(mk_req(OpResize, 8, 0, 1), mk_rsp(ST_BAD_INDEX, 0, 0, 0, 0));
    plan_req(mk_req(OpResize, 65, 0, 1), mk_rsp(ST_TOO_LARGE, 0, 0, 0, 0));
    // Count above capacity clamps to 1024; the store comes back full.
    plan_write(RegBlockCount, 32'd2047);
    plan_req(mk_req(OpFree, 0, 1023, 1), mk_rsp(ST_IGNORED, 0, 0, 0, 1024));
    // Block size below one link word acts as 8 bytes.
    plan_write(RegBlockSize, 32'd0);
    plan_req(mk_req(OpAlloc, 8, 0, 1), mk_rsp(ST_OK, 1, 1023, 8184, 1023));
    plan_req(mk_req(OpAlloc, 9, 0, 1), mk_rsp(ST_TOO_LARGE, 0, 0, 0, 1023));
    // Single-block pool at the largest block size.
    plan_write(RegBlockSize, 32'd65535);
    plan_write(RegBlockCount, 32'd1);
    plan_req(mk_req(OpAlloc, 65535, 0, 1), mk_rsp(ST_OK, 1, 0, 0, 0));
    plan_req(mk_req(OpAlloc, 0, 0, 1), mk_rsp(ST_EMPTY, 0, 0, 0, 0));
    plan_req(mk_req(OpFree, 0, 1, 1), mk_rsp(ST_BAD_INDEX, 0, 0, 0, 0));
    plan_req(mk_req(OpFree, 0, 0, 1), mk_rsp(ST_OK, 0, 0, 0, 1));
    plan_req(mk_req(OpResize, 65535, 0, 1), mk_rsp(ST_OK, 1, 0, 0, 1));

    // Random phases: extremes first, one fully random setting, small pools
    // so that the store swings between empty and full.
    phase_size  = '{64, 0, 65535, 8, 0, 300, 7, 1000};
    phase_count = '{1024, 4, 1, 1024, 0, 2047, 0, 16};
    phase_size[4]  = $urandom_range(0, 65535);
    phase_count[4] = $urandom_range(1, 1024);

    // Release reset at a falling edge.
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed plan.
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        write_reg(plan[i].addr, plan[i].value);
      end else begin
        hold_off($urandom_range(0, 7));
        issue(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    // Random part, checked against the pool model.
    for (int p = 0; p < NumPhases; p++) begin
      write_reg(reg_addr(RegBlockSize), phase_size[p]);
      write_reg(reg_addr(RegBlockCount), phase_count[p]);
      // A zero-block pool never grants a request: keep it short.
      phase_items = (phase_count[p] == 0) ? 40 : 150;
      burst = 1'b0;
      for (int n = 0; n < phase_items; n++) begin
        // Every 32 requests, decide whether to run back to back.
        if (n % 32 == 0) burst = ($urandom_range(0, 3) == 0);
        hold_off(burst ? 0 : $urandom_range(0, 7));
        issue(random_req(), 1'b0, '0);
      end
    end

    // Drain: wait for every owed result, then watch for stray strobes.
    start = 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("fixed_block_pool_allocator_top_test passed");
    end else begin
      $display("fixed_block_pool_allocator_top_test failed");
    end
    $finish;
  end

endmodule
